@@ sv/first_fit_heap_allocator_defines.svh @@
// Assertion macros for the first-fit heap allocator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ffha_pkg.sv @@
// Types, codes and constants of the first-fit heap allocator.
// No dependencies; used by the top level, the checker and the testbench.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES     = 1024 * 1024;
  localparam int unsigned HEADER_BYTES   = 32;
  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned ROUND_BYTES    = 8;
  localparam int unsigned SPLIT_MIN_RST  = 16;

  localparam int unsigned CAP_W = 21;  // capacities, offsets and the arena top
  localparam int unsigned POS_W = 23;  // sums of positions, headers and capacities
  localparam int unsigned SM_W  = 13;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_RESIZE  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_NOT_LIVE  = 3'd2,
    ST_DOUBLE    = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_RESIZE,
    OP_MOVE_ALLOC,
    OP_MOVE_FIND
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SCAN_RD, S_SCAN_CHK, S_HIT, S_MISS, S_AFTER,
    S_SH_RD, S_SH_WR, S_INS, S_MRG_RD, S_MRG_CHK, S_MRG_WR, S_BACK,
    S_GROW_RD, S_GROW_CHK, S_GROW_DEC, S_GROW_FIN, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      size;
    logic [CAP_W-1:0] offset;
    logic             offset_null;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [CAP_W-1:0] result_offset;
    logic             result_null;
    logic [CAP_W-1:0] copy_bytes;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] req;
  } entry_t;

endpackage

@@ sv/ffha_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: sequencer, datapath and block table.
// Depends on ffha_pkg and ffha_ram.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------
//  cfg      | in        | cfg_we_i              | cfg_wdata_i (split_min)
//  request  | in        | in_valid_i/in_stall_o | in_item_i
//  result   | out       | out_valid_o/out_stall_i | out_item_o
//
// One request at a time. Every walk of the block table (first-fit scan, offset
// lookup, free-neighbour sum, entry shifts for splits and merges) takes a read
// state and a check or write state per entry through the single table read port.
// Reset needs no clearing pass: entries at or above the block count are never read.
// A stalled result holds in the output register while the next item is taken.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffha_pkg::SM_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ffha_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ffha_pkg::out_item_t       out_item_o
);
  import ffha_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned NW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [POS_W-1:0] HDR  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] HEAP = POS_W'(HEAP_BYTES);

  state_e state_q, state_d, ret_q, ret_d;
  op_e    op_q, op_d;
  in_item_t req_q, req_d;
  entry_t cur_q, cur_d, prev_q, prev_d, ins_q, ins_d, e;
  logic [POS_W-1:0] need_q, need_d, pos_q, pos_d, acc_q, acc_d;
  logic [NW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, lim_q, lim_d, dist_q, dist_d;
  logic [NW-1:0] count_q, count_d;
  logic up_q, up_d, back_q, back_d;
  logic [CAP_W-1:0] top_q, top_d;
  logic [SM_W-1:0] sm_q;
  status_e st_q, st_d;
  logic [CAP_W-1:0] roff_q, roff_d, copy_q, copy_d;
  logic rnull_q, rnull_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [31:0] dfree_q, dfree_d, bfree_q, bfree_d;

  logic ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic in_acc, out_free;
  logic [32:0] need_full;
  logic oversize, is_alloc, find_op, alloc_op, scan_hit, full;
  logic [POS_W-1:0] split_thr, cur_rem, grow_rem, app_end, pos_next;
  logic cur_fits, cur_split, grow_split, app_fail, sh_done, cur_bad;

  assign e          = entry_t'(ram_rdata);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign need_full  = ({1'b0, req_q.size} + 33'(ROUND_BYTES)) & ~33'(ROUND_BYTES - 1);
  assign oversize   = (req_q.size > 32'(HEAP_BYTES)) || (need_full > 33'(HEAP_BYTES));
  assign is_alloc   = (req_q.action == ACT_ALLOC) ||
                      ((req_q.action == ACT_RESIZE) && req_q.offset_null);
  assign find_op    = (op_q == OP_RELEASE) || (op_q == OP_RESIZE) || (op_q == OP_MOVE_FIND);
  assign alloc_op   = (op_q == OP_ALLOC) || (op_q == OP_MOVE_ALLOC);
  assign scan_hit   = find_op ? ((pos_q + HDR) == POS_W'(req_q.offset))
                              : (!e.used && (POS_W'(e.cap) >= need_q));
  assign pos_next   = pos_q + HDR + POS_W'(e.cap);
  assign full       = count_q >= NW'(MAX_BLOCKS);
  assign split_thr  = HDR + POS_W'(sm_q);
  assign cur_rem    = POS_W'(cur_q.cap) - need_q;
  assign cur_fits   = POS_W'(cur_q.cap) >= need_q;
  assign cur_split  = (cur_rem >= split_thr) && !full;
  assign grow_rem   = acc_q - need_q;
  assign grow_split = (grow_rem >= split_thr) && !full;
  assign app_end    = POS_W'(top_q) + HDR + need_q;
  assign app_fail   = (app_end > HEAP) || full;
  assign sh_done    = up_q ? (j_q == lim_q) : (j_q == count_q);
  assign cur_bad    = !cur_q.used || (req_q.size > 32'(HEAP_BYTES));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = S_START;
      S_START: begin
        if (is_alloc) begin
          state_d = ((req_q.size == '0) || oversize) ? S_DONE : S_SCAN_RD;
        end else if ((req_q.action == ACT_RELEASE) || (req_q.action == ACT_RESIZE)) begin
          state_d = req_q.offset_null ? S_DONE : S_SCAN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_RD:  state_d = (i_q == count_q) ? S_MISS : S_SCAN_CHK;
      S_SCAN_CHK: state_d = scan_hit ? S_HIT : S_SCAN_RD;
      S_HIT: begin
        unique case (op_q)
          OP_ALLOC, OP_MOVE_ALLOC: state_d = cur_split ? S_SH_RD : S_AFTER;
          OP_RELEASE, OP_MOVE_FIND: state_d = cur_q.used ? S_MRG_RD : S_DONE;
          OP_RESIZE: begin
            if (cur_bad) state_d = S_DONE;
            else if (cur_fits) state_d = cur_split ? S_SH_RD : S_DONE;
            else state_d = S_GROW_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MISS:     state_d = (alloc_op && !app_fail) ? S_AFTER : S_DONE;
      S_AFTER:    state_d = (op_q == OP_MOVE_ALLOC) ? S_SCAN_RD : S_DONE;
      S_SH_RD:    state_d = sh_done ? ret_q : S_SH_WR;
      S_SH_WR:    state_d = S_SH_RD;
      S_INS:      state_d = alloc_op ? S_AFTER : S_DONE;
      S_MRG_RD:   state_d = ((i_q + NW'(1)) < count_q) ? S_MRG_CHK : S_MRG_WR;
      S_MRG_CHK:  state_d = e.used ? S_MRG_WR : S_SH_RD;
      S_MRG_WR:   state_d = (back_q && (i_q != '0) && !prev_q.used) ? S_BACK : S_DONE;
      S_BACK:     state_d = S_SH_RD;
      S_GROW_RD:  state_d = (j_q < count_q) ? S_GROW_CHK : S_GROW_DEC;
      S_GROW_CHK: state_d = e.used ? S_GROW_DEC : S_GROW_RD;
      S_GROW_DEC: begin
        if (acc_q >= need_q) state_d = S_SH_RD;
        else state_d = (need_q > HEAP) ? S_DONE : S_SCAN_RD;
      end
      S_GROW_FIN: state_d = grow_split ? S_SH_RD : S_DONE;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and table port.
  always_comb begin
    ret_d = ret_q;  op_d = op_q;  req_d = req_q;  cur_d = cur_q;  prev_d = prev_q;
    ins_d = ins_q;  need_d = need_q;  pos_d = pos_q;  acc_d = acc_q;  i_d = i_q;
    j_d = j_q;  k_d = k_q;  lim_d = lim_q;  dist_d = dist_q;  count_d = count_q;
    up_d = up_q;  back_d = back_q;  top_d = top_q;  st_d = st_q;  roff_d = roff_q;
    copy_d = copy_q;  rnull_d = rnull_q;  dfree_d = dfree_q;  bfree_d = bfree_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we = 1'b0;  ram_waddr = i_q;  ram_wdata = cur_q;  ram_raddr = i_q;

    unique case (state_q)
      S_IDLE: if (in_acc) req_d = in_item_i;
      S_START: begin
        need_d = need_full[POS_W-1:0];
        st_d = ST_OK;  roff_d = '0;  rnull_d = 1'b1;  copy_d = '0;
        i_d = '0;  pos_d = '0;  back_d = 1'b1;
        if (is_alloc) begin
          op_d = OP_ALLOC;
          if ((req_q.size != '0) && oversize) st_d = ST_OOM;
        end else if (req_q.action == ACT_RELEASE) begin
          op_d = OP_RELEASE;
        end else if (req_q.action == ACT_RESIZE) begin
          // Resize to zero behaves as a release.
          op_d = (req_q.size == '0) ? OP_RELEASE : OP_RESIZE;
        end else begin
          st_d = ST_NOT_LIVE;
        end
      end
      S_SCAN_RD: ram_raddr = i_q;
      S_SCAN_CHK: begin
        if (scan_hit) begin
          cur_d = e;
        end else begin
          prev_d = e;
          pos_d  = pos_next;
          i_d    = i_q + NW'(1);
        end
      end
      S_HIT: begin
        unique case (op_q)
          OP_ALLOC, OP_MOVE_ALLOC: begin
            ram_we = 1'b1;
            ram_wdata.used = 1'b1;
            ram_wdata.cap  = cur_split ? need_q[CAP_W-1:0] : cur_q.cap;
            ram_wdata.req  = req_q.size[CAP_W-1:0];
            roff_d = pos_d[CAP_W-1:0] + CAP_W'(HEADER_BYTES);
            rnull_d = 1'b0;
            if (cur_split) begin
              ins_d = '{used: 1'b0, cap: CAP_W'(cur_rem - HDR), req: '0};
              j_d = count_q;  lim_d = i_q + NW'(1);  up_d = 1'b1;  ret_d = S_INS;
            end
          end
          OP_RELEASE, OP_MOVE_FIND: begin
            if (!cur_q.used) begin
              dfree_d = dfree_q + 32'd1;
              st_d = ST_DOUBLE;
            end
            acc_d = POS_W'(cur_q.cap);
          end
          OP_RESIZE: begin
            if (!cur_q.used) begin
              st_d = ST_NOT_LIVE;
            end else if (req_q.size > 32'(HEAP_BYTES)) begin
              st_d = ST_OOM;
            end else if (cur_fits) begin
              ram_we = 1'b1;
              ram_wdata.cap = cur_split ? need_q[CAP_W-1:0] : cur_q.cap;
              ram_wdata.req = req_q.size[CAP_W-1:0];
              roff_d = req_q.offset;
              rnull_d = 1'b0;
              if (cur_split) begin
                // The new free tail then absorbs any free blocks behind it.
                acc_d = cur_rem - HDR;
                j_d = count_q;  lim_d = i_q + NW'(1);  up_d = 1'b1;  ret_d = S_MRG_RD;
                i_d = i_q + NW'(1);
                back_d = 1'b0;
              end
            end else begin
              acc_d = POS_W'(cur_q.cap);
              j_d = i_q + NW'(1);
              k_d = '0;
            end
          end
          default: ;
        endcase
      end
      S_MISS: begin
        if (alloc_op) begin
          if (app_fail) begin
            st_d = ST_OOM;  roff_d = '0;  rnull_d = 1'b1;  copy_d = '0;
          end else begin
            ram_we = 1'b1;
            ram_waddr = count_q;
            ram_wdata = '{used: 1'b1, cap: need_q[CAP_W-1:0],
                          req: req_q.size[CAP_W-1:0]};
            count_d = count_q + NW'(1);
            top_d = app_end[CAP_W-1:0];
            roff_d = top_q + CAP_W'(HEADER_BYTES);
            rnull_d = 1'b0;
          end
        end else if (op_q == OP_RELEASE) begin
          bfree_d = bfree_q + 32'd1;
          st_d = ST_BAD_FREE;
        end else if (op_q == OP_RESIZE) begin
          st_d = ST_NOT_LIVE;
        end
      end
      S_AFTER: begin
        if (op_q == OP_MOVE_ALLOC) begin
          op_d = OP_MOVE_FIND;  i_d = '0;  pos_d = '0;
        end
      end
      S_SH_RD: begin
        ram_raddr = up_q ? (j_q - NW'(1)) : j_q;
        if (sh_done) count_d = up_q ? (count_q + NW'(1)) : (count_q - dist_q);
      end
      S_SH_WR: begin
        ram_we = 1'b1;
        ram_waddr = up_q ? j_q : (j_q - dist_q);
        ram_wdata = e;
        j_d = up_q ? (j_q - NW'(1)) : (j_q + NW'(1));
      end
      S_INS: begin
        ram_we = 1'b1;
        ram_waddr = lim_q;
        ram_wdata = ins_q;
      end
      S_MRG_RD: ram_raddr = i_q + NW'(1);
      S_MRG_CHK: begin
        if (!e.used) begin
          acc_d = acc_q + HDR + POS_W'(e.cap);
          j_d = i_q + NW'(2);  dist_d = NW'(1);  up_d = 1'b0;  ret_d = S_MRG_RD;
        end
      end
      S_MRG_WR: begin
        ram_we = 1'b1;
        ram_wdata = '{used: 1'b0, cap: acc_q[CAP_W-1:0], req: '0};
      end
      S_BACK: begin
        ram_we = 1'b1;
        ram_waddr = i_q - NW'(1);
        ram_wdata = '{used: 1'b0, cap: CAP_W'(POS_W'(prev_q.cap) + HDR + acc_q), req: '0};
        j_d = i_q + NW'(1);  dist_d = NW'(1);  up_d = 1'b0;  ret_d = S_DONE;
      end
      S_GROW_RD: ram_raddr = j_q;
      S_GROW_CHK: begin
        if (!e.used) begin
          acc_d = acc_q + HDR + POS_W'(e.cap);
          k_d = k_q + NW'(1);
          j_d = j_q + NW'(1);
        end
      end
      S_GROW_DEC: begin
        if (acc_q >= need_q) begin
          // Drop the absorbed free blocks; j already points past them.
          dist_d = k_q;  up_d = 1'b0;  ret_d = S_GROW_FIN;
        end else if (need_q > HEAP) begin
          st_d = ST_OOM;
        end else begin
          copy_d = ({11'd0, cur_q.req} < req_q.size) ? cur_q.req : req_q.size[CAP_W-1:0];
          op_d = OP_MOVE_ALLOC;  i_d = '0;  pos_d = '0;
        end
      end
      S_GROW_FIN: begin
        ram_we = 1'b1;
        ram_wdata.used = 1'b1;
        ram_wdata.cap  = grow_split ? need_q[CAP_W-1:0] : acc_q[CAP_W-1:0];
        ram_wdata.req  = req_q.size[CAP_W-1:0];
        roff_d = req_q.offset;
        rnull_d = 1'b0;
        if (grow_split) begin
          ins_d = '{used: 1'b0, cap: CAP_W'(grow_rem - HDR), req: '0};
          j_d = count_q;  lim_d = i_q + NW'(1);  up_d = 1'b1;  ret_d = S_INS;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: st_q, result_offset: rnull_q ? '0 : roff_q,
                    result_null: rnull_q, copy_bytes: copy_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      sm_q        <= SM_W'(SPLIT_MIN_RST);
      out_valid_q <= 1'b0;
      dfree_q     <= '0;
      bfree_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      dfree_q     <= dfree_d;
      bfree_q     <= bfree_d;
      if (cfg_we_i) sm_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  op_q <= op_d;  req_q <= req_d;  cur_q <= cur_d;  prev_q <= prev_d;
    ins_q <= ins_d;  need_q <= need_d;  pos_q <= pos_d;  acc_q <= acc_d;  i_q <= i_d;
    j_q <= j_d;  k_q <= k_d;  lim_q <= lim_d;  dist_q <= dist_d;  up_q <= up_d;
    back_q <= back_d;  st_q <= st_d;  roff_q <= roff_d;  copy_q <= copy_d;
    rnull_q <= rnull_d;  out_q <= out_d;
  end

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[IW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/ffha_chk.sv @@
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_defines.svh.
`include "first_fit_heap_allocator_defines.svh"

module ffha_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [ffha_pkg::SM_W-1:0] cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input ffha_pkg::in_item_t        in_item_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input ffha_pkg::out_item_t       out_item_o
);
  import ffha_pkg::*;

  // Only one item is in work at a time.
  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "item taken while busy")
  `FFHA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")
  `FFHA_ASSERT_SAME(a_null_offset, out_valid_o && out_item_o.result_null, out_item_o.result_offset == '0, "null result with offset")
  `FFHA_ASSERT_SAME(a_fail_no_block, out_valid_o && (out_item_o.status != ST_OK), out_item_o.result_null && (out_item_o.copy_bytes == '0), "failed request returned a block")

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (.*);

@@ dv/tb_first_fit_heap_allocator.sv @@
// Self-checking testbench of the first-fit heap allocator: directed table, then random traffic.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL; holds its own model of the heap.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam int unsigned TBL_DEPTH = MAX_BLOCKS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 2200;
  localparam int unsigned PHASE_ITEMS = 240;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SM_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  first_fit_heap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the block table and allocator registers.
  bit              e_used [TBL_DEPTH];
  longint unsigned e_cap  [TBL_DEPTH];
  longint unsigned e_req  [TBL_DEPTH];
  int unsigned     n_blk = 0;
  longint unsigned arena_top = 0;
  longint unsigned split_min = SPLIT_MIN_RST;
  int unsigned     double_frees = 0;
  int unsigned     bad_frees = 0;

  out_item_t answers_due [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  function automatic void tbl_drop(int unsigned i);
    if (i >= n_blk) return;
    for (int unsigned k = i; k + 1 < n_blk; k++) begin
      e_used[k] = e_used[k+1];
      e_cap[k]  = e_cap[k+1];
      e_req[k]  = e_req[k+1];
    end
    n_blk--;
  endfunction

  function automatic bit tbl_insert(int unsigned i, bit u, longint unsigned c,
                                    longint unsigned r);
    if (n_blk >= TBL_DEPTH || i > n_blk) return 1'b0;
    for (int k = int'(n_blk); k > int'(i); k--) begin
      e_used[k] = e_used[k-1];
      e_cap[k]  = e_cap[k-1];
      e_req[k]  = e_req[k-1];
    end
    e_used[i] = u;
    e_cap[i]  = c;
    e_req[i]  = r;
    n_blk++;
    return 1'b1;
  endfunction

  function automatic int locate(longint unsigned off);
    longint unsigned pos;
    pos = 0;
    for (int k = 0; k < int'(n_blk); k++) begin
      if (pos + HEADER_BYTES == off) return k;
      pos += HEADER_BYTES + e_cap[k];
    end
    return -1;
  endfunction

  function automatic void absorb_next(int unsigned i);
    e_cap[i] += HEADER_BYTES + e_cap[i+1];
    tbl_drop(i + 1);
  endfunction

  function automatic void free_at(int unsigned i);
    e_used[i] = 1'b0;
    e_req[i]  = 0;
    while (i + 1 < n_blk && !e_used[i+1]) absorb_next(i);
    if (i > 0 && !e_used[i-1]) absorb_next(i - 1);
  endfunction

  function automatic status_e heap_free(longint unsigned off);
    int f;
    f = locate(off);
    if (f < 0) begin
      bad_frees++;
      return ST_BAD_FREE;
    end
    if (!e_used[f]) begin
      double_frees++;
      return ST_DOUBLE;
    end
    free_at(f);
    return ST_OK;
  endfunction

  function automatic status_e heap_alloc(longint unsigned size, output longint unsigned off,
                                         output bit isnull);
    longint unsigned cap, pos, rem;
    off = 0;
    isnull = 1'b1;
    pos = 0;
    if (size == 0) return ST_OK;
    if (size > HEAP_BYTES) return ST_OOM;
    cap = (size + ROUND_BYTES) & ~64'd7;
    if (cap > HEAP_BYTES) return ST_OOM;
    for (int unsigned i = 0; i < n_blk; i++) begin
      if (!e_used[i] && e_cap[i] >= cap) begin
        rem = e_cap[i] - cap;
        if (rem >= HEADER_BYTES + split_min && tbl_insert(i + 1, 1'b0, rem - HEADER_BYTES, 0))
          e_cap[i] = cap;
        e_used[i] = 1'b1;
        e_req[i]  = size;
        off = pos + HEADER_BYTES;
        isnull = 1'b0;
        return ST_OK;
      end
      pos += HEADER_BYTES + e_cap[i];
    end
    if (arena_top + HEADER_BYTES + cap > HEAP_BYTES) return ST_OOM;
    if (!tbl_insert(n_blk, 1'b1, cap, size)) return ST_OOM;
    off = arena_top + HEADER_BYTES;
    isnull = 1'b0;
    arena_top += HEADER_BYTES + cap;
    return ST_OK;
  endfunction

  function automatic status_e heap_resize(longint unsigned size, longint unsigned off,
                                          output longint unsigned roff, output bit isnull,
                                          output longint unsigned copy);
    int f;
    int unsigned i;
    longint unsigned want, total, rem, noff;
    status_e st;
    roff = 0;
    isnull = 1'b1;
    copy = 0;
    if (size == 0) return heap_free(off);
    f = locate(off);
    if (f < 0 || !e_used[f]) return ST_NOT_LIVE;
    i = f;
    if (size > HEAP_BYTES) return ST_OOM;
    want = (size + ROUND_BYTES) & ~64'd7;
    if (e_cap[i] >= want) begin
      rem = e_cap[i] - want;
      if (rem >= HEADER_BYTES + split_min && tbl_insert(i + 1, 1'b0, rem - HEADER_BYTES, 0)) begin
        e_cap[i] = want;
        while (i + 2 < n_blk && !e_used[i+2]) absorb_next(i + 1);
      end
      e_req[i] = size;
      roff = off;
      isnull = 1'b0;
      return ST_OK;
    end
    total = e_cap[i];
    for (int unsigned j = i + 1; j < n_blk && !e_used[j]; j++)
      total += HEADER_BYTES + e_cap[j];
    if (total >= want) begin
      while (i + 1 < n_blk && !e_used[i+1]) tbl_drop(i + 1);
      rem = total - want;
      if (!(rem >= HEADER_BYTES + split_min &&
            tbl_insert(i + 1, 1'b0, rem - HEADER_BYTES, 0)))
        want = total;
      e_cap[i] = want;
      e_req[i] = size;
      roff = off;
      isnull = 1'b0;
      return ST_OK;
    end
    // No room in place: the block moves and the smaller of the two sizes is copied.
    total = (e_req[i] < size) ? e_req[i] : size;
    st = heap_alloc(size, noff, isnull);
    if (st != ST_OK || isnull) begin
      isnull = 1'b1;
      return ST_OOM;
    end
    f = locate(off);
    if (f >= 0 && e_used[f]) free_at(f);
    roff = noff;
    copy = total;
    return ST_OK;
  endfunction

  function automatic out_item_t heap_answer(in_item_t it);
    out_item_t res;
    status_e st;
    longint unsigned roff, copy;
    bit isnull;
    roff = 0;
    copy = 0;
    isnull = 1'b1;
    case (it.action)
      ACT_ALLOC:   st = heap_alloc(it.size, roff, isnull);
      ACT_RELEASE: st = it.offset_null ? ST_OK : heap_free(it.offset);
      ACT_RESIZE: begin
        if (it.offset_null) st = heap_alloc(it.size, roff, isnull);
        else st = heap_resize(it.size, it.offset, roff, isnull, copy);
      end
      default:     st = ST_NOT_LIVE;
    endcase
    res.status        = st;
    res.result_offset = isnull ? '0 : roff[CAP_W-1:0];
    res.result_null   = isnull;
    res.copy_bytes    = copy[CAP_W-1:0];
    return res;
  endfunction

  // User offset of a random block that is, or is not, in use.
  function automatic longint unsigned pick_block(bit want_used, output bit found);
    longint unsigned pos;
    longint unsigned cand [$];
    pos = 0;
    for (int unsigned k = 0; k < n_blk; k++) begin
      if (e_used[k] == want_used) cand.push_back(pos + HEADER_BYTES);
      pos += HEADER_BYTES + e_cap[k];
    end
    found = cand.size() != 0;
    return found ? cand[$urandom_range(0, cand.size() - 1)] : 0;
  endfunction

  function automatic logic [31:0] rand_size(bit tiny);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tiny) return $urandom_range(1, 24);
    if (r < 60) return $urandom_range(1, 256);
    if (r < 78) return $urandom_range(257, 4096);
    if (r < 84) return 0;
    if (r < 92) return $urandom_range(4097, 200000);
    if (r < 96) return $urandom_range(HEAP_BYTES - 64, HEAP_BYTES + 8);
    return $urandom;
  endfunction

  function automatic in_item_t gen_item(bit fill);
    in_item_t it;
    int unsigned r, sel;
    bit found;
    it.action      = ACT_ALLOC;
    it.size        = rand_size(fill);
    it.offset      = $urandom;
    it.offset_null = $urandom_range(0, 1);
    r = $urandom_range(0, 99);
    if (fill ? r < 85 : r < 40) return it;
    if (r >= 95) begin
      // Noise: an undefined action, or any action with arbitrary fields.
      it.action = ($urandom_range(0, 1) != 0) ? ACT_UNDEFINED : 2'($urandom);
      it.size   = $urandom;
      return it;
    end
    it.action = (r < 70) ? ACT_RELEASE : ACT_RESIZE;
    it.offset_null = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      it.offset = pick_block(1'b1, found);
      if (!found) it.offset = $urandom;
    end else if (sel < 85) begin
      it.offset = pick_block(1'b0, found);
      if (!found) it.offset = $urandom_range(0, HEAP_BYTES);
    end else if (sel < 95) begin
      it.offset = pick_block(1'b1, found) + 8 * $urandom_range(0, 1);
      if ($urandom_range(0, 1) != 0) it.offset = $urandom_range(0, HEAP_BYTES);
    end else begin
      it.offset_null = 1'b1;
    end
    return it;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // Offers one item and books its expected result at the edge it is taken.
  task automatic offer_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    res = heap_answer(it);
    answers_due.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_split_min(logic [SM_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    split_min = v;
  endtask

  // Receiver stall pattern: switches among four modes when the stall_left countdown runs out.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 100;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= $urandom_range(0, 1);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          note_error($sformatf("result with nothing expected: %p", out_item_o));
        end else begin
          exp_res = answers_due.pop_front();
          if (out_item_o.status !== exp_res.status ||
              out_item_o.result_offset !== exp_res.result_offset ||
              out_item_o.result_null !== exp_res.result_null ||
              out_item_o.copy_bytes !== exp_res.copy_bytes)
            note_error($sformatf("expected %p, got %p", exp_res, out_item_o));
        end
      end
    end
  end

  typedef struct {
    logic [1:0]       act;
    logic [31:0]      size;
    logic [CAP_W-1:0] off;
    bit               nul;
    bit               pick_live;
    bit               typed;
    out_item_t        res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic row(logic [1:0] act, logic [31:0] size, logic [CAP_W-1:0] off, bit nul,
                     bit pick_live, bit typed, status_e st, logic [CAP_W-1:0] roff, bit rnull);
    dir_row_t d;
    d.act = act; d.size = size; d.off = off; d.nul = nul;
    d.pick_live = pick_live; d.typed = typed;
    d.res.status = st; d.res.result_offset = roff;
    d.res.result_null = rnull; d.res.copy_bytes = '0;
    dir_rows.push_back(d);
  endtask

  initial begin
    in_item_t it;
    bit found;
    int unsigned burst_left, gap;
    logic [SM_W-1:0] phase_split [6];

    phase_split = '{13'd8, 13'd4096, 13'd8191, 13'd0, 13'($urandom), 13'd16};

    // Extremes, error codes and the plain cases of each action.
    row(ACT_ALLOC, 0, 0, 0, 0, 1, ST_OK, 0, 1);
    row(ACT_ALLOC, HEAP_BYTES + 1, 0, 0, 0, 1, ST_OOM, 0, 1);
    row(ACT_ALLOC, 32'hFFFF_FFFF, 0, 0, 0, 1, ST_OOM, 0, 1);
    row(ACT_ALLOC, HEAP_BYTES, 0, 0, 0, 1, ST_OOM, 0, 1);
    row(ACT_ALLOC, 1, 0, 0, 0, 1, ST_OK, HEADER_BYTES, 0);
    row(ACT_RELEASE, 0, '1, 1, 0, 1, ST_OK, 0, 1);
    row(ACT_RELEASE, 0, HEADER_BYTES, 0, 0, 1, ST_OK, 0, 1);
    row(ACT_RELEASE, 0, HEADER_BYTES, 0, 0, 1, ST_DOUBLE, 0, 1);
    row(ACT_RELEASE, 0, HEADER_BYTES + 1, 0, 0, 1, ST_BAD_FREE, 0, 1);
    row(ACT_RESIZE, 5, HEADER_BYTES, 0, 0, 1, ST_NOT_LIVE, 0, 1);
    row(ACT_UNDEFINED, '1, '1, 1, 0, 1, ST_NOT_LIVE, 0, 1);
    row(ACT_ALLOC, 100, 0, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_ALLOC, 200, 0, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_RESIZE, 40, 72, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_RESIZE, 90, 72, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_RESIZE, 5000, 72, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_RESIZE, 64, 0, 1, 0, 0, ST_OK, 0, 0);
    row(ACT_RESIZE, 32'hFFFF_FFFF, 0, 0, 1, 1, ST_OOM, 0, 1);
    row(ACT_RESIZE, 0, 0, 0, 1, 1, ST_OK, 0, 1);
    row(ACT_ALLOC, HEAP_BYTES - 40, 0, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_RELEASE, 0, 0, 0, 0, 1, ST_BAD_FREE, 0, 1);
    row(ACT_ALLOC, 8, 0, 0, 0, 0, ST_OK, 0, 0);
    row(ACT_ALLOC, 7, 0, 0, 0, 0, ST_OK, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      it.action = dir_rows[k].act;
      it.size = dir_rows[k].size;
      it.offset = dir_rows[k].off;
      it.offset_null = dir_rows[k].nul;
      if (dir_rows[k].pick_live) it.offset = pick_block(1'b1, found);
      offer_item(it, dir_rows[k].typed, dir_rows[k].res);
    end

    burst_left = $urandom_range(1, 30);
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_split_min(phase_split[ph]);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // The first phase leans on tiny allocations so that the table fills up.
        it = gen_item(ph == 0);
        offer_item(it, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          burst_left = $urandom_range(1, 30);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator.sv
sv/ffha_chk.sv
dv/tb_first_fit_heap_allocator.sv
